### design/cpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpt_pkg: shared types and constants of the convex polygon point test
// Field widths fixed by the item format, command codes, register map and the
// control word that travels with each queued item.
// ----------------------------------------------------------------------------
package cpt_pkg;

  // Fixed field widths
  localparam int IDX_W = 4;   // vertex_index
  localparam int CNT_W = 5;   // vertex_count register
  localparam int OUT_DW = 8;  // result tdata, one flag padded to a byte

  // Smallest polygon the test accepts
  localparam int MIN_VERTICES = 3;

  // Item commands (in_tuser)
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Register map: paddr[2] selects the register word
  localparam int CFG_AW = 3;
  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = CNT_W'(MIN_VERTICES);

  // Control word of one queued item
  typedef struct packed {
    logic             cmd;
    logic [IDX_W-1:0] idx;
  } cpt_ctl_t;

endpackage

### design/cpt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpt_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module cpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/cpt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpt_front: item intake and classification
// Unpacks input items, drops vertex writes to slots beyond the table, and
// holds the rest in a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module cpt_front #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 16
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   in_tvalid,
  output logic                                                   in_tready,
  input  logic [((cpt_pkg::IDX_W + 2*COORD_BITS + 7)/8)*8-1:0]   in_tdata,
  input  logic                                                   in_tuser,
  output logic                                                   q_valid,
  input  logic                                                   q_ready,
  output cpt_pkg::cpt_ctl_t                                      q_ctl,
  output logic [COORD_BITS-1:0]                                  q_x,
  output logic [COORD_BITS-1:0]                                  q_y
);
  import cpt_pkg::*;

  localparam int QDEPTH = 2;

  logic [IDX_W-1:0]      in_idx;
  logic [COORD_BITS-1:0] in_x;
  logic [COORD_BITS-1:0] in_y;
  logic                  keep;
  logic                  push;
  logic                  pop;

  cpt_ctl_t              ctl_r [QDEPTH];
  logic [COORD_BITS-1:0] x_r   [QDEPTH];
  logic [COORD_BITS-1:0] y_r   [QDEPTH];
  logic                  wptr_r;
  logic                  rptr_r;
  logic [1:0]            count_r;

  // Unpack the item
  assign in_idx = in_tdata[IDX_W-1:0];
  assign in_x   = in_tdata[IDX_W +: COORD_BITS];
  assign in_y   = in_tdata[IDX_W+COORD_BITS +: COORD_BITS];

  // Classify: drop writes that fall outside the table
  assign keep = (in_tuser == CMD_QUERY) || (32'(in_idx) < MAX_VERTICES);

  assign in_tready = (count_r != 2'(QDEPTH));
  assign push      = in_tvalid && in_tready && keep;
  assign pop       = q_valid && q_ready;

  assign q_valid = (count_r != 2'd0);
  assign q_ctl   = ctl_r[rptr_r];
  assign q_x     = x_r[rptr_r];
  assign q_y     = y_r[rptr_r];

  // Store accepted items
  always_ff @(posedge clk) begin
    if (push) begin
      ctl_r[wptr_r] <= '{cmd: in_tuser, idx: in_idx};
      x_r[wptr_r]   <= in_x;
      y_r[wptr_r]   <= in_y;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### design/cpt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpt_back: vertex table and edge-sign engine
// Executes vertex writes and point tests. A test streams the vertices out of
// the table one per cycle, forms one exact cross product per edge through a
// three-stage pipe, and folds the signs into the inside flag.
// ----------------------------------------------------------------------------
module cpt_back #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  cpt_pkg::cpt_ctl_t             q_ctl,
  input  logic [COORD_BITS-1:0]         q_x,
  input  logic [COORD_BITS-1:0]         q_y,
  input  logic [cpt_pkg::CNT_W-1:0]     vertex_count,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic                          res_inside
);
  import cpt_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int DW = COORD_BITS + 1;   // vertex minus point
  localparam int PW = 2 * DW;           // one product
  localparam int SW = PW + 1;           // cross product
  localparam int RW = 2 * COORD_BITS;   // packed vertex

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_WAIT  = 3'b100
  } cpt_state_t;

  cpt_state_t state_r, state_nxt;

  logic [CW-1:0]         n_clamp;
  logic [CW-1:0]         n_r;
  logic [CW-1:0]         k_r;
  logic [COORD_BITS-1:0] px_r, py_r;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [RW-1:0]         ram_rdata;
  logic [COORD_BITS-1:0] rx, ry;

  logic                  pop_write, pop_query;

  logic                  s1_v_r, s1_first_r, s1_close_r;
  logic signed [DW-1:0]  dx_new, dy_new;
  logic signed [DW-1:0]  d0x_r, d0y_r, dcx_r, dcy_r, dpx_r, dpy_r;
  logic                  e_v_r, e_last_r;
  logic signed [PW-1:0]  m1_r, m2_r;
  logic                  m_v_r, m_last_r;
  logic signed [SW-1:0]  xprod;
  logic                  s_nz, s_neg;
  logic                  ref_nz_r, ref_neg_r, inside_r;
  logic                  inside_nxt;
  logic                  res_v_r, res_inside_r;

  // Clamp the polygon size to the table
  always_comb begin
    if (vertex_count < CNT_W'(MIN_VERTICES)) begin
      n_clamp = CW'(MIN_VERTICES);
    end else if (32'(vertex_count) > MAX_VERTICES) begin
      n_clamp = CW'(MAX_VERTICES);
    end else begin
      n_clamp = CW'(vertex_count);
    end
  end

  // Take a write any time in idle, a test only when the result slot is free
  assign q_ready   = (state_r == ST_IDLE) && ((q_ctl.cmd == CMD_WRITE) || !res_v_r);
  assign pop_write = q_valid && q_ready && (q_ctl.cmd == CMD_WRITE);
  assign pop_query = q_valid && q_ready && (q_ctl.cmd == CMD_QUERY);

  assign ram_we    = pop_write;
  assign ram_waddr = AW'(q_ctl.idx);

  cpt_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_VERTICES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({q_y, q_x}),
    .raddr (k_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rx = ram_rdata[COORD_BITS-1:0];
  assign ry = ram_rdata[RW-1:COORD_BITS];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (pop_query) state_nxt = ST_ISSUE;
      ST_ISSUE: if (k_r == n_r) state_nxt = ST_WAIT;
      ST_WAIT:  if (m_v_r && m_last_r) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Stage 1: vertex minus point, or wrap to the first vertex on the closing edge
  always_comb begin
    if (s1_close_r) begin
      dx_new = d0x_r;
      dy_new = d0y_r;
    end else begin
      dx_new = $signed({rx[COORD_BITS-1], rx}) - $signed({px_r[COORD_BITS-1], px_r});
      dy_new = $signed({ry[COORD_BITS-1], ry}) - $signed({py_r[COORD_BITS-1], py_r});
    end
  end

  // Stage 3: sign of the cross product and the running verdict
  assign xprod = $signed({m1_r[PW-1], m1_r}) - $signed({m2_r[PW-1], m2_r});
  assign s_nz  = |xprod;
  assign s_neg = xprod[SW-1];

  always_comb begin
    inside_nxt = inside_r;
    if (ref_nz_r && s_nz && (s_neg != ref_neg_r)) begin
      inside_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      s1_v_r  <= 1'b0;
      e_v_r   <= 1'b0;
      m_v_r   <= 1'b0;
      res_v_r <= 1'b0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= (state_r == ST_ISSUE);
      e_v_r   <= s1_v_r && !s1_first_r;
      m_v_r   <= e_v_r;
      if (pop_query) begin
        k_r <= '0;
      end else if (state_r == ST_ISSUE) begin
        k_r <= k_r + CW'(1);
      end
      if (res_v_r && res_ready) begin
        res_v_r <= 1'b0;
      end
      if ((state_r == ST_WAIT) && m_v_r && m_last_r) begin
        res_v_r <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    // Latch the test point and size
    if (pop_query) begin
      px_r     <= q_x;
      py_r     <= q_y;
      n_r      <= n_clamp;
      ref_nz_r <= 1'b0;
      inside_r <= 1'b1;
    end
    // Step flags ride with the read
    s1_first_r <= (k_r == '0);
    s1_close_r <= (k_r == n_r);
    // Shift the vertex differences
    if (s1_v_r) begin
      dcx_r <= dx_new;
      dcy_r <= dy_new;
      dpx_r <= dcx_r;
      dpy_r <= dcy_r;
      if (s1_first_r) begin
        d0x_r <= dx_new;
        d0y_r <= dy_new;
      end
    end
    e_last_r <= s1_close_r;
    // Stage 2: the two products of the edge
    m1_r     <= dpx_r * dcy_r;
    m2_r     <= dpy_r * dcx_r;
    m_last_r <= e_last_r;
    // Fold the edge sign
    if (m_v_r) begin
      inside_r <= inside_nxt;
      if (!ref_nz_r && s_nz) begin
        ref_nz_r  <= 1'b1;
        ref_neg_r <= s_neg;
      end
    end
    if ((state_r == ST_WAIT) && m_v_r && m_last_r) begin
      res_inside_r <= inside_nxt;
    end
  end

  assign res_valid  = res_v_r;
  assign res_inside = res_inside_r;

endmodule

### design/convex_polygon_point_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convex_polygon_point_test: point-in-convex-polygon test
// Keeps a vertex table and answers inside/outside for query points by the
// signs of the edge cross products.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on in_*. in_tuser = 0 writes vertex (coord_x, coord_y)
//   into slot vertex_index; in_tuser = 1 tests point (coord_x, coord_y)
//   against the first vertex_count vertices. A write gives no result; a test
//   gives one item on out_* with inside_res = 1 for inside or on an edge.
//   vertex_count is set over the cfg_ APB port (clamped to 3..MAX_VERTICES
//   when used) and must only change while the block is idle.
// Timing:
//   A two-entry queue takes items while the engine works. A write is stored
//   into the table as it is dequeued. A test streams one vertex per cycle out
//   of the table memory through a three-stage cross-product pipe; the verdict
//   goes to the result register and then to the output register. Tests run
//   one at a time: no item is dequeued until the running test is done.
// Reset and stall:
//   Reset empties the queue and pipe and sets vertex_count to 3; table
//   contents stay undefined until written. A stalled out_tready holds the
//   result; one more may finish behind it, then the engine takes only writes.
// ----------------------------------------------------------------------------
module convex_polygon_point_test #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 16
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  // Items in
  input  logic                                                 in_tvalid,
  output logic                                                 in_tready,
  // vertex_index[3:0], coord_x, coord_y, zero fill
  input  logic [((cpt_pkg::IDX_W + 2*COORD_BITS + 7)/8)*8-1:0] in_tdata,
  // cmd
  input  logic                                                 in_tuser,
  // Results out
  output logic                                                 out_tvalid,
  input  logic                                                 out_tready,
  // inside_res[0], zero fill
  output logic [cpt_pkg::OUT_DW-1:0]                           out_tdata,
  // Configuration
  input  logic                                                 cfg_psel,
  input  logic                                                 cfg_penable,
  input  logic                                                 cfg_pwrite,
  input  logic [cpt_pkg::CFG_AW-1:0]                           cfg_paddr,
  input  logic [31:0]                                          cfg_pwdata,
  output logic [31:0]                                          cfg_prdata,
  output logic                                                 cfg_pready
);
  import cpt_pkg::*;

  logic                  q_valid;
  logic                  q_ready;
  cpt_ctl_t              q_ctl;
  logic [COORD_BITS-1:0] q_x;
  logic [COORD_BITS-1:0] q_y;
  logic                  res_valid;
  logic                  res_ready;
  logic                  res_inside;

  logic [CNT_W-1:0]      vertex_count_r;
  logic                  cfg_wr;
  logic                  out_tvalid_r;
  logic                  out_inside_r;

  // Register access
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[CFG_AW-1] == REG_VERTEX_COUNT);
  assign cfg_prdata = (cfg_paddr[CFG_AW-1] == REG_VERTEX_COUNT) ?
                      {{(32-CNT_W){1'b0}}, vertex_count_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= VERTEX_COUNT_RST;
    end else if (cfg_wr) begin
      vertex_count_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  cpt_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_ctl     (q_ctl),
    .q_x       (q_x),
    .q_y       (q_y)
  );

  cpt_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_ctl        (q_ctl),
    .q_x          (q_x),
    .q_y          (q_y),
    .vertex_count (vertex_count_r),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_inside   (res_inside)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_inside_r <= res_inside;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DW-1){1'b0}}, out_inside_r};

endmodule
